// ----- hdl/slr_pkg.sv -----
// ----------------------------------------------------------------------------
// slr_pkg
// Types and constants shared by the stream literal replace unit.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int LEN_W       = 4;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              byte_present;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_present;
        logic              last_of_run;
        logic              text_done;
    } out_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]  pattern_len;
        logic [WORD_W-1:0] replacement_bytes;
        logic [LEN_W-1:0]  replacement_len;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [LEN_W-1:0]  count;
        logic              present;
        logic              done;
    } run_t;

endpackage

// ----- hdl/slr_config.sv -----
// ----------------------------------------------------------------------------
// slr_config
// Configuration registers with clamped effective lengths.
// ----------------------------------------------------------------------------
module slr_config #(
    parameter int MAX_PATTERN_BYTES     = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [slr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slr_pkg::WORD_W-1:0]       cfg_wdata,
    output slr_pkg::cfg_t                    cfg,
    output logic                             clear_window
);

    logic [slr_pkg::WORD_W-1:0] pattern_bytes_reg;
    logic [slr_pkg::WORD_W-1:0] pattern_bytes_next;
    logic [slr_pkg::LEN_W-1:0]  pattern_len_reg;
    logic [slr_pkg::LEN_W-1:0]  pattern_len_next;
    logic [slr_pkg::WORD_W-1:0] replacement_bytes_reg;
    logic [slr_pkg::WORD_W-1:0] replacement_bytes_next;
    logic [slr_pkg::LEN_W-1:0]  replacement_len_reg;
    logic [slr_pkg::LEN_W-1:0]  replacement_len_next;

    always_comb
    begin
        pattern_bytes_next     = pattern_bytes_reg;
        pattern_len_next       = pattern_len_reg;
        replacement_bytes_next = replacement_bytes_reg;
        replacement_len_next   = replacement_len_reg;
        clear_window           = 1'b0;
        if (cfg_we)
        begin
            unique case (slr_pkg::cfg_reg_t'(cfg_index))
                slr_pkg::REG_PATTERN_BYTES:
                    pattern_bytes_next = cfg_wdata;
                slr_pkg::REG_PATTERN_LENGTH:
                begin
                    pattern_len_next = cfg_wdata[slr_pkg::LEN_W-1:0];
                    clear_window     = 1'b1;
                end
                slr_pkg::REG_REPLACEMENT_BYTES:
                    replacement_bytes_next = cfg_wdata;
                slr_pkg::REG_REPLACEMENT_LENGTH:
                    replacement_len_next = cfg_wdata[slr_pkg::LEN_W-1:0];
                default:
                    clear_window = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg     <= '0;
            pattern_len_reg       <= slr_pkg::LEN_W'(1);
            replacement_bytes_reg <= '0;
            replacement_len_reg   <= '0;
        end
        else
        begin
            pattern_bytes_reg     <= pattern_bytes_next;
            pattern_len_reg       <= pattern_len_next;
            replacement_bytes_reg <= replacement_bytes_next;
            replacement_len_reg   <= replacement_len_next;
        end
    end

    // effective lengths
    always_comb
    begin
        cfg.pattern_bytes     = pattern_bytes_reg;
        cfg.replacement_bytes = replacement_bytes_reg;
        if (pattern_len_reg == '0)
            cfg.pattern_len = slr_pkg::LEN_W'(1);
        else if (pattern_len_reg > slr_pkg::LEN_W'(MAX_PATTERN_BYTES))
            cfg.pattern_len = slr_pkg::LEN_W'(MAX_PATTERN_BYTES);
        else
            cfg.pattern_len = pattern_len_reg;
        if (replacement_len_reg > slr_pkg::LEN_W'(MAX_REPLACEMENT_BYTES))
            cfg.replacement_len = slr_pkg::LEN_W'(MAX_REPLACEMENT_BYTES);
        else
            cfg.replacement_len = replacement_len_reg;
    end

endmodule

// ----- hdl/slr_window.sv -----
// ----------------------------------------------------------------------------
// slr_window
// Pending byte window, pattern compare and result run assembly.
// ----------------------------------------------------------------------------
module slr_window #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  slr_pkg::in_item_t item,
    input  logic              accept,
    input  slr_pkg::cfg_t     cfg,
    input  logic              clear_window,
    output slr_pkg::run_t     run
);

    localparam int BW = slr_pkg::BYTE_W;
    localparam int LW = slr_pkg::LEN_W;

    logic [BW-1:0] win_reg [MAX_PATTERN_BYTES];
    logic [BW-1:0] win_next [MAX_PATTERN_BYTES];
    logic [LW-1:0] cnt_reg;
    logic [LW-1:0] cnt_next;

    logic [BW-1:0]             new_win [MAX_PATTERN_BYTES];
    logic [LW-1:0]             cnt_inc;
    logic                      full;
    logic                      match;
    logic [slr_pkg::WORD_W-1:0] packed_win;

    always_comb
    begin
        cnt_inc = cnt_reg + {{(LW-1){1'b0}}, item.byte_present};
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            if (item.byte_present && cnt_reg == LW'(i))
                new_win[i] = item.text_byte;
            else
                new_win[i] = win_reg[i];
        end

        full  = item.byte_present && (cnt_inc == cfg.pattern_len);
        match = full;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            if (LW'(i) < cfg.pattern_len && new_win[i] != cfg.pattern_bytes[BW*i +: BW])
                match = 1'b0;
        end

        packed_win = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            packed_win[BW*i +: BW] = new_win[i];

        win_next    = new_win;
        cnt_next    = cnt_inc;
        run.bytes   = '0;
        run.count   = '0;
        run.present = 1'b1;
        run.done    = item.end_of_text;

        if (match)
        begin
            run.bytes = cfg.replacement_bytes;
            run.count = cfg.replacement_len;
            cnt_next  = '0;
        end
        else if (full)
        begin
            // no match: front byte leaves, window shifts by one; at end of text the whole window leaves
            for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++)
                win_next[i] = new_win[i+1];
            cnt_next = cfg.pattern_len - LW'(1);
            if (item.end_of_text)
            begin
                run.bytes = packed_win;
                run.count = cfg.pattern_len;
            end
            else
            begin
                run.bytes[BW-1:0] = new_win[0];
                run.count         = LW'(1);
            end
        end
        else if (item.end_of_text)
        begin
            run.bytes = packed_win;
            run.count = cnt_inc;
        end

        if (item.end_of_text)
        begin
            cnt_next = '0;
            // end marker with no characters
            if (run.count == '0)
            begin
                run.count   = LW'(1);
                run.present = 1'b0;
                run.bytes   = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (clear_window)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

endmodule

// ----- hdl/slr_drain.sv -----
// ----------------------------------------------------------------------------
// slr_drain
// Pending run slot and serializer that hands out one result per transaction.
// ----------------------------------------------------------------------------
module slr_drain (
    input  logic               clk,
    input  logic               rst_n,
    input  slr_pkg::run_t      run,
    input  logic               run_push,
    output logic               run_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output slr_pkg::out_item_t result_item
);

    localparam int BW = slr_pkg::BYTE_W;
    localparam int LW = slr_pkg::LEN_W;

    slr_pkg::run_t              pend_reg;
    slr_pkg::run_t              pend_next;
    logic                       pend_valid_reg;
    logic                       pend_valid_next;
    logic [slr_pkg::WORD_W-1:0] bytes_reg;
    logic [slr_pkg::WORD_W-1:0] bytes_next;
    logic [LW-1:0]              left_reg;
    logic [LW-1:0]              left_next;
    logic                       present_reg;
    logic                       present_next;
    logic                       done_reg;
    logic                       done_next;

    logic cur_free;
    logic pop;
    logic load;

    assign pop      = result_valid && result_ready;
    assign cur_free = (left_reg == '0) || (left_reg == LW'(1) && result_ready);
    assign load     = pend_valid_reg && cur_free;
    assign run_ready = !pend_valid_reg || cur_free;

    always_comb
    begin
        bytes_next      = bytes_reg;
        left_next       = left_reg;
        present_next    = present_reg;
        done_next       = done_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (pop)
        begin
            bytes_next = bytes_reg >> BW;
            left_next  = left_reg - LW'(1);
        end
        if (load)
        begin
            bytes_next      = pend_reg.bytes;
            left_next       = pend_reg.count;
            present_next    = pend_reg.present;
            done_next       = pend_reg.done;
            pend_valid_next = 1'b0;
        end
        if (run_push)
        begin
            pend_next       = run;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg   <= bytes_next;
        present_reg <= present_next;
        done_reg    <= done_next;
        pend_reg    <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg       <= left_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    assign result_valid            = (left_reg != '0);
    assign result_item.out_byte    = bytes_reg[BW-1:0];
    assign result_item.out_present = present_reg;
    assign result_item.last_of_run = (left_reg == LW'(1));
    assign result_item.text_done   = done_reg && (left_reg == LW'(1));

endmodule

// ----- hdl/stream_literal_replace_unit.sv -----
// ----------------------------------------------------------------------------
// stream_literal_replace_unit
// Streaming literal find-and-replace over a byte stream.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  text     | text_valid, text_ready, text_item     | in
//  result   | result_valid, result_ready, result_item | out
//  config   | cfg_we, cfg_index, cfg_wdata          | in
//
//  an input transaction is taken when text_valid and text_ready are both high;
//  its run is registered in the pending slot, then loaded into the result
//  serializer, which offers its results at one per cycle while result_ready
//  is held high; the result serializer sets the rate; a one-run slot between
//  window and serializer takes one more run while results wait, then input
//  stalls; reset clears the window count and all valid state
// ----------------------------------------------------------------------------
module stream_literal_replace_unit #(
    parameter int MAX_PATTERN_BYTES     = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            text_valid,
    output logic                            text_ready,
    input  slr_pkg::in_item_t               text_item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output slr_pkg::out_item_t              result_item,
    input  logic                            cfg_we,
    input  logic [slr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slr_pkg::WORD_W-1:0]      cfg_wdata
);

    slr_pkg::cfg_t cfg;
    slr_pkg::run_t run;
    logic          clear_window;
    logic          accept;
    logic          run_ready;

    assign text_ready = run_ready;
    assign accept     = text_valid && run_ready;

    slr_config #(
        .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
        .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
    ) u_config (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cfg          (cfg),
        .clear_window (clear_window)
    );

    slr_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (text_item),
        .accept       (accept),
        .cfg          (cfg),
        .clear_window (clear_window),
        .run          (run)
    );

    slr_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .run          (run),
        .run_push     (accept),
        .run_ready    (run_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

// ----- hdl/slr_checker.sv -----
// ----------------------------------------------------------------------------
// slr_checker
// Port-level checks on the result channel of the replace unit.
// ----------------------------------------------------------------------------
module slr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input slr_pkg::out_item_t result_item
);

    // a stalled transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result changed while stalled");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.text_done |-> result_item.last_of_run)
        else $error("text_done without last_of_run");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.out_present |-> result_item.out_byte == 8'd0)
        else $error("end marker carries a byte");

    a_marker_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.out_present |->
            result_item.text_done && result_item.last_of_run)
        else $error("empty result outside end of text");

endmodule

bind stream_literal_replace_unit slr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);
